/* rtl/lss_pkg.sv */
// shared types and codes for the lifo stack with search
package lss_pkg;

    // default number of stored keys
    localparam int DEPTH_DEF = 64;

    // request kinds
    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_SEARCH = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_LIST   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // request word
    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] key_name;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] entry_name;
        logic        last_of_run;
    } t_out_word;

endpackage

/* rtl/lss_mem.sv */
// key store: one write port, one registered read port
module lss_mem #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [63:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [63:0]   o_rd_data
);
    import lss_pkg::*;

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/lss_ctrl.sv */
// request sequencer: fill count, walk pointer and key store access
module lss_ctrl #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lss_pkg::t_in_word i_in_word,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output lss_pkg::t_out_word o_res_word
);
    import lss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [2:0]    r_req, n_req;
    logic [63:0]   r_key, n_key;

    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] ptr_m1;
    logic          is_full;
    logic          is_empty;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;
    logic          res_valid;
    t_out_word     res_word;

    lss_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cnt_m1   = r_count - CW'(1);
    assign ptr_m1   = r_ptr - AW'(1);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // sequencing of each request
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_req     = r_req;
        n_key     = r_key;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = cnt_m1[AW-1:0];
        res_valid = 1'b0;
        res_word  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // take the word and fetch the top entry
                    n_req = i_in_word.req_type;
                    n_key = i_in_word.key_name;
                    rd_en = 1'b1;
                    n_ptr = cnt_m1[AW-1:0];
                    if (i_in_word.req_type <= REQ_LIST) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (i_res_ready) begin
                    res_word.last_of_run = 1'b1;
                    case (r_req)
                        REQ_PUSH: begin
                            res_valid = 1'b1;
                            n_state   = S_IDLE;
                            if (is_full) begin
                                res_word.status = ST_FULL;
                            end else begin
                                res_word.status = ST_DONE;
                                wr_en           = 1'b1;
                                n_count         = r_count + CW'(1);
                            end
                        end
                        REQ_POP: begin
                            res_valid = 1'b1;
                            n_state   = S_IDLE;
                            if (is_empty) begin
                                res_word.status = ST_EMPTY;
                            end else begin
                                res_word.status     = ST_DONE;
                                res_word.entry_name = rd_data;
                                n_count             = cnt_m1;
                            end
                        end
                        REQ_SEARCH: begin
                            if (is_empty) begin
                                res_valid       = 1'b1;
                                res_word.status = ST_EMPTY;
                                n_state         = S_IDLE;
                            end else if (rd_data == r_key) begin
                                res_valid           = 1'b1;
                                res_word.status     = ST_FOUND;
                                res_word.entry_name = r_key;
                                n_state             = S_IDLE;
                            end else if (r_ptr == '0) begin
                                res_valid       = 1'b1;
                                res_word.status = ST_NOT_FOUND;
                                n_state         = S_IDLE;
                            end else begin
                                // step down one entry
                                rd_en   = 1'b1;
                                rd_addr = ptr_m1;
                                n_ptr   = ptr_m1;
                            end
                        end
                        REQ_CLEAR, REQ_LIST: begin
                            res_valid = 1'b1;
                            if (is_empty) begin
                                res_word.status = ST_EMPTY;
                                n_state         = S_IDLE;
                            end else begin
                                res_word.status      = ST_DONE;
                                res_word.entry_name  = rd_data;
                                res_word.last_of_run = (r_ptr == '0);
                                if (r_ptr == '0) begin
                                    n_state = S_IDLE;
                                    if (r_req == REQ_CLEAR) begin
                                        n_count = '0;
                                    end
                                end else begin
                                    rd_en   = 1'b1;
                                    rd_addr = ptr_m1;
                                    n_ptr   = ptr_m1;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // request payload and walk pointer
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_req <= n_req;
        r_key <= n_key;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = res_valid;
    assign o_res_word  = res_word;

    // fill count stays within the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // a result is only offered when the output stage can take it
    a_res_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> i_res_ready)
        else $error("result offered while output stage busy");

    // the last result of a request hands control back to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_word.last_of_run |=> r_state == S_IDLE)
        else $error("not idle after last result");

    // a push that fits grows the store by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow the store");

endmodule

/* rtl/lifo_stack_with_search.sv */
// lifo_stack_with_search: bounded key stack with top-down search, clear and list
//
// Input channel i_in_valid / o_in_stall carries one request word: a kind (push,
// pop, search, clear, list) and a 64-bit key. Output channel o_out_valid /
// i_out_stall carries result words: status, key and a last flag that marks
// the final result of the request. Undefined kinds are taken and dropped.
// A request is taken only while the sequencer is idle. On taking a request the
// sequencer fetches the top entry from the key store, whose read port is
// registered; push and pop then finish in the execute state. Search, clear and
// list walk the store from the top at one entry per cycle while the output
// register can be loaded, and clear and list give one result per stored entry.
// A result appears on the output register in the cycle after it is formed.
// When the receiver stalls, the output register holds its word and the walk
// pauses on the current entry until the register can be loaded again.
// Synchronous reset empties the store (fill count to zero) and clears the
// output valid flag; the store contents are not cleared and need no pass.
module lifo_stack_with_search #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lss_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lss_pkg::t_out_word o_out_word
);
    import lss_pkg::*;

    logic      r_out_valid;
    t_out_word r_out_word;
    logic      res_ready;
    logic      res_valid;
    t_out_word res_word;

    // output register can load when empty or being taken
    assign res_ready = !r_out_valid || !i_out_stall;

    lss_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res_word  (res_word)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
